### design/tsc_pkg.sv
package tsc_pkg;

   localparam int unsigned SampleWidth = 8;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 16;

   // Register indexes on the csr port
   localparam logic [CsrAddrWidth-1:0] CSR_SETTLE_DISCARD = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_PASS_THRESHOLD = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_CAPTURE_COUNT  = 2'd2;

   localparam logic [CountWidth-1:0]  SettleReset    = 16'd200;
   localparam logic [SampleWidth-1:0] ThresholdReset = 8'hFF;
   localparam logic [CountWidth-1:0]  CaptureReset   = 16'd0;

   // Kind of an input word, carried on req_tuser
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE    = 2'd0,
      PHASE_SETTLE  = 2'd1,
      PHASE_WAIT    = 2'd2,
      PHASE_CAPTURE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CountWidth-1:0]  index;
      logic [SampleWidth-1:0] value;
   } result_type;

endpackage

### design/triggered_sample_capture_top.sv
// Triggered sample capture.
// Input stream req_*: one word per converter sample (req_tuser = 1) or a start
// command (req_tuser = 0). A start arms a run: the next settle_discard_count
// samples are dropped, then the first sample at or below pass_threshold opens
// the capture window (that sample itself is not emitted), then capture_count
// samples go out on rsp_* with their index in the run; rsp_tlast marks the
// final one and the block falls back to idle. Samples seen while idle are
// dropped; a start during a run restarts it.
// Configuration: csr_we writes csr_wdata to register csr_addr (0 settle count,
// 1 threshold, 2 capture count). Write only while the block is idle.
// Timing: one input word per cycle while req_tready is high. The phase and counter
// update is a single compare-and-increment per word; the result is registered at
// the edge that accepts its sample: the output register, or the skid entry if full.
// Stall: the output register is backed by one skid entry, so one more result
// is held while a result waits; req_tready drops only when both hold a result.
// Reset (synchronous, active high) restores the register defaults (200, 255,
// 0), puts the block in idle and empties the output stage.
module triggered_sample_capture_top
   import tsc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SampleWidth-1:0]  req_tdata,   // [7:0] sample_value
   input  logic                    req_tuser,   // [0] op
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [23:0]             rsp_tdata,   // [7:0] captured_value, [23:8] sample_index
   output logic                    rsp_tlast,   // last
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   logic [CountWidth-1:0]  settle_ff;
   logic [SampleWidth-1:0] threshold_ff;
   logic [CountWidth-1:0]  capture_ff;

   phase_type             phase_ff, phase_in;
   logic [CountWidth-1:0] dropped_ff, dropped_in;
   logic [CountWidth-1:0] captured_ff, captured_in;

   result_type out_ff, skid_ff, result;
   logic       out_valid_ff, skid_valid_ff;
   logic       out_last_ff, skid_last_ff, result_last;

   logic accept, emit, take, threshold_hit;
   logic [CountWidth-1:0] dropped_inc, captured_inc;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;
   assign take       = out_valid_ff && rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.index, out_ff.value};
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff    <= SettleReset;
         threshold_ff <= ThresholdReset;
         capture_ff   <= CaptureReset;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SETTLE_DISCARD: settle_ff    <= csr_wdata;
            CSR_PASS_THRESHOLD: threshold_ff <= csr_wdata[SampleWidth-1:0];
            CSR_CAPTURE_COUNT:  capture_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dropped_inc   = dropped_ff + 16'd1;
   assign captured_inc  = captured_ff + 16'd1;
   assign threshold_hit = req_tdata <= threshold_ff;

   always_comb begin
      phase_in     = phase_ff;
      dropped_in   = dropped_ff;
      captured_in  = captured_ff;
      emit         = 1'b0;
      result.value = req_tdata;
      result.index = captured_ff;
      result_last  = 1'b0;
      if (accept) begin
         if (req_tuser == OP_START) begin
            phase_in    = PHASE_SETTLE;
            dropped_in  = '0;
            captured_in = '0;
         end else begin
            unique case (phase_ff)
               PHASE_IDLE: ;
               PHASE_SETTLE, PHASE_WAIT: begin
                  if (phase_ff == PHASE_SETTLE && dropped_ff < settle_ff) begin
                     // drop a settling sample
                     dropped_in = dropped_inc;
                     if (dropped_inc >= settle_ff) phase_in = PHASE_WAIT;
                  end else if (threshold_hit) begin
                     captured_in = '0;
                     phase_in    = (capture_ff == '0) ? PHASE_IDLE : PHASE_CAPTURE;
                  end else begin
                     phase_in = PHASE_WAIT;
                  end
               end
               PHASE_CAPTURE: begin
                  if (captured_ff >= capture_ff) begin
                     phase_in = PHASE_IDLE;
                  end else begin
                     emit        = 1'b1;
                     captured_in = captured_inc;
                     result_last = captured_inc >= capture_ff;
                     if (result_last) phase_in = PHASE_IDLE;
                  end
               end
               default: phase_in = PHASE_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_IDLE;
         dropped_ff  <= '0;
         captured_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         dropped_ff  <= dropped_in;
         captured_ff <= captured_in;
      end
   end

   // Output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= emit;
         end
      end else if (emit) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_ff      <= skid_ff;
            out_last_ff <= skid_last_ff;
         end else if (emit) begin
            out_ff      <= result;
            out_last_ff <= result_last;
         end
      end else if (emit) begin
         // hold the new word until the output register drains
         skid_ff      <= result;
         skid_last_ff <= result_last;
      end
   end

endmodule

### design/tsc_checker.sv
module tsc_checker
   import tsc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [SampleWidth-1:0] req_tdata,
   input logic                   req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [23:0]            rsp_tdata,
   input logic                   rsp_tlast
);

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Backpressure only while results are queued
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty output stage");

   // A fresh result comes only from a sample word taken the cycle before
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !$past(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tuser))
      else $error("result without a sample word");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("start word produced a result");

endmodule

bind triggered_sample_capture_top tsc_checker u_tsc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
